[hw/rtl/mtg_pkg.sv]
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared widths, codes and types of the membrane thickness grid unit.
// ----------------------------------------------------------------------------
package mtg_pkg;

    // Field widths
    localparam int OP_W       = 3;
    localparam int COORD_W    = 24;
    localparam int KIND_W     = 4;
    localparam int CELL_W     = 7;
    localparam int STATUS_W   = 2;
    localparam int NH_W       = 10;
    localparam int GAP_W      = 24;
    localparam int SUM_W      = 48;
    localparam int HITS_W     = 16;
    localparam int GRID_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Coordinate precision kept from the input fields
    localparam int COORD_BITS = 24;
    localparam logic [COORD_W-1:0] CMASK = (COORD_BITS >= COORD_W) ?
        {COORD_W{1'b1}} : COORD_W'((64'd1 << COORD_BITS) - 64'd1);

    // Distance datapath widths (doubled units)
    localparam int DBL_W  = COORD_W + 1;      // doubled coordinate
    localparam int SEP_W  = 32;               // raw axis difference
    localparam int LEN_W  = COORD_W + 1;      // doubled box length
    localparam int AXS_W  = 31;               // saturated axis separation
    localparam int D2_W   = 2 * AXS_W + 1;    // sum of two squares
    localparam int THR_W  = 2 * COORD_W + 2;  // 4 * box_x * box_y
    localparam logic [AXS_W-1:0] AXIS_LIM = {AXS_W{1'b1}};

    // Defaults for module parameters
    localparam int DEF_MAX_HEADS = 1024;
    localparam int DEF_MAX_PROT  = 1024;
    localparam int DEF_MAX_GRID  = 128;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLR_FRAME = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_HEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_LOAD_PROT = 3'd2;
    localparam logic [OP_W-1:0] OP_PAIR      = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY     = 3'd4;
    localparam logic [OP_W-1:0] OP_CLR_MAP   = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PROT_EN = 3'd5;

    // Configuration reset values
    localparam logic [COORD_W-1:0] RST_BOX  = 24'd655360;
    localparam logic [COORD_W-1:0] RST_STEP = 24'd10240;
    localparam logic [GRID_W-1:0]  RST_GRID = 8'd64;

    // Thickness map port control
    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } t_map_ctl;

endpackage

[hw/rtl/mtg_in_if.sv]
// ----------------------------------------------------------------------------
// mtg_in_if
// Input item channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface mtg_in_if;
    import mtg_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic                leaflet;
    logic [COORD_W-1:0]  pos_x;
    logic [COORD_W-1:0]  pos_y;
    logic [COORD_W-1:0]  pos_z;
    logic [KIND_W-1:0]   lipid_kind;
    logic [CELL_W-1:0]   cell_col;
    logic [CELL_W-1:0]   cell_row;

    modport source (output valid, op, leaflet, pos_x, pos_y, pos_z, lipid_kind,
                    cell_col, cell_row, input ready);
    modport sink   (input valid, op, leaflet, pos_x, pos_y, pos_z, lipid_kind,
                    cell_col, cell_row, output ready);
endinterface

[hw/rtl/mtg_out_if.sv]
// ----------------------------------------------------------------------------
// mtg_out_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface mtg_out_if;
    import mtg_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [NH_W-1:0]     nearest_head;
    logic [KIND_W-1:0]   nearest_kind;
    logic [GAP_W-1:0]    gap_value;
    logic                protein_hit;
    logic [SUM_W-1:0]    map_total;
    logic [SUM_W-1:0]    frame_total;
    logic [HITS_W-1:0]   frame_hits;

    modport source (output valid, status, nearest_head, nearest_kind, gap_value,
                    protein_hit, map_total, frame_total, frame_hits, input ready);
    modport sink   (input valid, status, nearest_head, nearest_kind, gap_value,
                    protein_hit, map_total, frame_total, frame_hits, output ready);
endinterface

[hw/rtl/mtg_axis_mod.sv]
// ----------------------------------------------------------------------------
// mtg_axis_mod
// Minimum-image separation along one axis: iterative remainder by the
// doubled box length, four quotient bits per cycle, then fold and saturate.
// ----------------------------------------------------------------------------
module mtg_axis_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mtg_pkg::SEP_W-1:0]   i_diff,
    input  logic [mtg_pkg::LEN_W-1:0]   i_len,
    output logic                        o_done,
    output logic [mtg_pkg::AXS_W-1:0]   o_sep
);
    import mtg_pkg::*;

    localparam int BITS  = 4;
    localparam int ITER  = SEP_W / BITS;
    localparam int CNT_W = $clog2(ITER);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [SEP_W-1:0]   r_dvd;
    logic [SEP_W-1:0]   r_orig;
    logic [LEN_W:0]     r_rem;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W:0]     n_rem;
    logic [SEP_W-1:0]   n_dvd;

    // Shift in four dividend bits and reduce after each
    always_comb begin
        n_rem = r_rem;
        n_dvd = r_dvd;
        for (int i = 0; i < BITS; i++) begin
            n_rem = {n_rem[LEN_W-1:0], n_dvd[SEP_W-1]};
            n_dvd = {n_dvd[SEP_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_len}) begin
                n_rem = n_rem - {1'b0, r_len};
            end
        end
    end

    // Sequence the remainder steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_dvd  <= '0;
            r_orig <= '0;
            r_rem  <= '0;
            r_len  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_diff;
                r_orig <= i_diff;
                r_rem  <= '0;
                r_len  <= i_len;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= n_dvd;
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Fold to the nearest image; no wrap for a zero box
    always_comb begin
        if (r_len == '0) begin
            o_sep = (r_orig > SEP_W'(AXIS_LIM)) ? AXIS_LIM : AXS_W'(r_orig);
        end else if ({r_rem[LEN_W-1:0], 1'b0} > {1'b0, r_len}) begin
            o_sep = AXS_W'(r_len - r_rem[LEN_W-1:0]);
        end else begin
            o_sep = AXS_W'(r_rem[LEN_W-1:0]);
        end
    end

    assign o_done = r_done;

endmodule

[hw/rtl/mtg_dist.sv]
// ----------------------------------------------------------------------------
// mtg_dist
// Periodic planar squared distance between two points in doubled units.
// ----------------------------------------------------------------------------
module mtg_dist (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mtg_pkg::SEP_W-1:0]   i_ax,
    input  logic [mtg_pkg::SEP_W-1:0]   i_ay,
    input  logic [mtg_pkg::SEP_W-1:0]   i_bx,
    input  logic [mtg_pkg::SEP_W-1:0]   i_by,
    input  logic [mtg_pkg::LEN_W-1:0]   i_len_x,
    input  logic [mtg_pkg::LEN_W-1:0]   i_len_y,
    output logic                        o_done,
    output logic [mtg_pkg::D2_W-1:0]    o_d2
);
    import mtg_pkg::*;

    logic [SEP_W-1:0]     diff_x;
    logic [SEP_W-1:0]     diff_y;
    logic                 x_done;
    logic                 y_done;
    logic [AXS_W-1:0]     sep_x;
    logic [AXS_W-1:0]     sep_y;
    logic                 r_sq_v;
    logic [2*AXS_W-1:0]   r_sqx;
    logic [2*AXS_W-1:0]   r_sqy;
    logic                 r_done;
    logic [D2_W-1:0]      r_d2;

    // Absolute differences per axis
    assign diff_x = (i_ax > i_bx) ? i_ax - i_bx : i_bx - i_ax;
    assign diff_y = (i_ay > i_by) ? i_ay - i_by : i_by - i_ay;

    mtg_axis_mod u_mod_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_diff  (diff_x),
        .i_len   (i_len_x),
        .o_done  (x_done),
        .o_sep   (sep_x)
    );

    mtg_axis_mod u_mod_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_diff  (diff_y),
        .i_len   (i_len_y),
        .o_done  (y_done),
        .o_sep   (sep_y)
    );

    // Square each axis, then add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v <= 1'b0;
            r_done <= 1'b0;
            r_sqx  <= '0;
            r_sqy  <= '0;
            r_d2   <= '0;
        end else begin
            r_sq_v <= x_done & y_done;
            r_done <= r_sq_v;
            if (x_done & y_done) begin
                r_sqx <= sep_x * sep_x;
                r_sqy <= sep_y * sep_y;
            end
            if (r_sq_v) begin
                r_d2 <= {1'b0, r_sqx} + {1'b0, r_sqy};
            end
        end
    end

    assign o_done = r_done;
    assign o_d2   = r_d2;

endmodule

[hw/rtl/mtg_map.sv]
// ----------------------------------------------------------------------------
// mtg_map
// Thickness map memory: one read and one write port, with a clearing sweep
// after reset and on request.
// ----------------------------------------------------------------------------
module mtg_map #(
    parameter int MAX_GRID = mtg_pkg::DEF_MAX_GRID
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  mtg_pkg::t_map_ctl                         i_ctl,
    input  logic [$clog2(MAX_GRID*MAX_GRID)-1:0]      i_addr,
    input  logic [mtg_pkg::SUM_W-1:0]                 i_wdata,
    output logic [mtg_pkg::SUM_W-1:0]                 o_rdata,
    output logic                                      o_busy
);
    import mtg_pkg::*;

    localparam int DEPTH  = MAX_GRID * MAX_GRID;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [SUM_W-1:0]   mem [DEPTH];
    logic               r_busy;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [SUM_W-1:0]   r_rdata;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [SUM_W-1:0]   wr_data;

    // Sweep has priority over ordinary writes
    assign wr_en   = r_busy | i_ctl.wr;
    assign wr_addr = r_busy ? r_clr_addr : i_addr;
    assign wr_data = r_busy ? '0 : i_wdata;

    // Advance the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (i_ctl.clr) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Memory array
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_ctl.rd) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

[hw/rtl/membrane_thickness_grid_unit.sv]
// ----------------------------------------------------------------------------
// membrane_thickness_grid_unit
// Head and protein point stores, pair pass and grid cell query with a
// persistent per-cell thickness map.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake        Payload
// i_in      in   valid/ready      op, leaflet, pos_x/y/z, lipid_kind, cell_col/row
// o_out     out  valid/ready      status, nearest_*, gap_value, protein_hit, totals
// i_cfg_*   in   write enable     register index, data
//
// Each distance takes a store read, a read wait and a pass through the shared
// distance unit with its remainder divider; a query runs one distance per head
// of its leaflet and up to one per protein atom, and a pair pass one per pair of
// reference and other-leaflet head. Clear map sweeps all MAX_GRID^2 entries, one
// entry a cycle; the same sweep runs after reset, and no item is taken meanwhile.
// A result waiting on o_out holds back only the end of the next item.
// ----------------------------------------------------------------------------
module membrane_thickness_grid_unit #(
    parameter int MAX_HEADS = mtg_pkg::DEF_MAX_HEADS,
    parameter int MAX_PROT  = mtg_pkg::DEF_MAX_PROT,
    parameter int MAX_GRID  = mtg_pkg::DEF_MAX_GRID
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mtg_in_if.sink                           i_in,
    mtg_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [mtg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mtg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mtg_pkg::*;

    localparam int HA    = $clog2(2 * MAX_HEADS);
    localparam int HIW   = $clog2(MAX_HEADS);
    localparam int CW    = $clog2(MAX_HEADS + 1);
    localparam int PIW   = $clog2(MAX_PROT);
    localparam int PCW   = $clog2(MAX_PROT + 1);
    localparam int MA    = $clog2(MAX_GRID * MAX_GRID);
    localparam int HD_W  = 3 * COORD_W + KIND_W;
    localparam int PR_W  = 2 * COORD_W;
    localparam int ST_W  = 5;

    localparam logic [ST_W-1:0] S_IDLE    = 5'd0;
    localparam logic [ST_W-1:0] S_DECODE  = 5'd1;
    localparam logic [ST_W-1:0] S_CLRW    = 5'd2;
    localparam logic [ST_W-1:0] S_FIN     = 5'd3;
    localparam logic [ST_W-1:0] S_PP_REF  = 5'd4;
    localparam logic [ST_W-1:0] S_PP_REFW = 5'd5;
    localparam logic [ST_W-1:0] S_PP_RD   = 5'd6;
    localparam logic [ST_W-1:0] S_PP_RDW  = 5'd7;
    localparam logic [ST_W-1:0] S_PP_DIST = 5'd8;
    localparam logic [ST_W-1:0] S_PP_WR   = 5'd9;
    localparam logic [ST_W-1:0] S_Q_SETUP = 5'd10;
    localparam logic [ST_W-1:0] S_Q_RD    = 5'd11;
    localparam logic [ST_W-1:0] S_Q_RDW   = 5'd12;
    localparam logic [ST_W-1:0] S_Q_DIST  = 5'd13;
    localparam logic [ST_W-1:0] S_Q_PROT0 = 5'd14;
    localparam logic [ST_W-1:0] S_P_RD    = 5'd15;
    localparam logic [ST_W-1:0] S_P_RDW   = 5'd16;
    localparam logic [ST_W-1:0] S_P_DIST  = 5'd17;
    localparam logic [ST_W-1:0] S_Q_MAPRD = 5'd18;
    localparam logic [ST_W-1:0] S_Q_MAPW  = 5'd19;

    // Configuration
    logic [COORD_W-1:0]  r_box_x, r_box_y, r_step_x, r_step_y;
    logic [GRID_W-1:0]   r_grid;
    logic                r_prot_en;

    // Latched item
    logic [OP_W-1:0]     r_op;
    logic                r_lf;
    logic [COORD_W-1:0]  r_px, r_py, r_pz;
    logic [KIND_W-1:0]   r_kind;
    logic [CELL_W-1:0]   r_col, r_row;

    // Control state
    logic [ST_W-1:0]     r_state;
    logic [CW-1:0]       r_cnt0, r_cnt1;
    logic [PCW-1:0]      r_pcnt;
    logic [SUM_W-1:0]    r_fsum;
    logic [HITS_W-1:0]   r_fcnt;
    logic [HIW-1:0]      r_k, r_m, r_bk;
    logic [PIW-1:0]      r_j;
    logic                r_found;

    // Working values
    logic [THR_W-1:0]    r_thr;
    logic [D2_W-1:0]     r_best;
    logic [SEP_W-1:0]    r_cx, r_cy;
    logic [DBL_W-1:0]    r_rx, r_ry;
    logic [COORD_W-1:0]  r_rz, r_bz;
    logic [KIND_W-1:0]   r_bkind;
    logic [GAP_W-1:0]    r_bgap;
    logic [MA-1:0]       r_cell;

    // Result being built and the output register
    logic [STATUS_W-1:0] r_st;
    logic [NH_W-1:0]     r_nh;
    logic [KIND_W-1:0]   r_nk;
    logic [GAP_W-1:0]    r_gp;
    logic                r_hit;
    logic [SUM_W-1:0]    r_mt;
    logic                r_ov;
    logic [STATUS_W-1:0] r_o_st;
    logic [NH_W-1:0]     r_o_nh;
    logic [KIND_W-1:0]   r_o_nk;
    logic [GAP_W-1:0]    r_o_gp;
    logic                r_o_hit;
    logic [SUM_W-1:0]    r_o_mt, r_o_ft;
    logic [HITS_W-1:0]   r_o_fh;

    // Memories
    logic [HD_W-1:0]     head_mem [2 * MAX_HEADS];
    logic [GAP_W-1:0]    gap_mem  [2 * MAX_HEADS];
    logic [PR_W-1:0]     prot_mem [MAX_PROT];
    logic [HD_W-1:0]     r_hd_q;
    logic [GAP_W-1:0]    r_gap_q;
    logic [PR_W-1:0]     r_pr_q;

    logic                in_fire;
    logic [CW-1:0]       cnt_ref, cnt_oth;
    logic                hd_sel_lf;
    logic [HIW-1:0]      hd_idx;
    logic [HA-1:0]       hd_addr;
    logic                hd_rd, hd_we, gap_we, pr_rd, pr_we;
    logic [GAP_W-1:0]    gap_wdata;
    logic [COORD_W-1:0]  hd_x, hd_y, hd_z;
    logic [KIND_W-1:0]   hd_kind;
    logic [COORD_W-1:0]  pm_x, pm_y;
    logic [COORD_W-1:0]  in_px, in_py, in_pz;
    logic                dist_start;
    logic [SEP_W-1:0]    dist_ax, dist_ay, dist_bx, dist_by;
    logic                dist_done;
    logic [D2_W-1:0]     dist_d2;
    t_map_ctl            map_ctl;
    logic [SUM_W-1:0]    map_rdata, map_wdata;
    logic                map_busy;
    logic [SUM_W:0]      map_sum, fsum_sum;
    logic                add_ok;
    logic [COORD_W-1:0]  pp_gap;

    assign in_fire = i_in.valid & i_in.ready;
    assign i_in.ready = (r_state == S_IDLE) & ~map_busy;

    assign in_px = i_in.pos_x & CMASK;
    assign in_py = i_in.pos_y & CMASK;
    assign in_pz = i_in.pos_z & CMASK;

    assign cnt_ref = r_lf ? r_cnt1 : r_cnt0;
    assign cnt_oth = r_lf ? r_cnt0 : r_cnt1;

    assign {hd_x, hd_y, hd_z, hd_kind} = r_hd_q;
    assign {pm_x, pm_y} = r_pr_q;

    // Select the head store entry for this state
    always_comb begin
        hd_sel_lf = r_lf;
        hd_idx    = r_k;
        hd_rd     = 1'b0;
        hd_we     = 1'b0;
        gap_we    = 1'b0;
        gap_wdata = '0;
        pr_rd     = 1'b0;
        pr_we     = 1'b0;
        case (r_state)
            S_DECODE: begin
                hd_idx = HIW'(cnt_ref);
                if (r_op == OP_LOAD_HEAD && cnt_ref < CW'(MAX_HEADS)) begin
                    hd_we  = 1'b1;
                    gap_we = 1'b1;
                end
                if (r_op == OP_LOAD_PROT && r_pcnt < PCW'(MAX_PROT)) begin
                    pr_we = 1'b1;
                end
            end
            S_PP_REF: hd_rd = 1'b1;
            S_PP_RD: begin
                hd_sel_lf = ~r_lf;
                hd_idx    = r_m;
                hd_rd     = 1'b1;
            end
            S_PP_WR: begin
                gap_we    = 1'b1;
                gap_wdata = pp_gap;
            end
            S_Q_RD: hd_rd = 1'b1;
            S_P_RD: pr_rd = 1'b1;
            default: ;
        endcase
    end

    assign hd_addr = hd_sel_lf ? HA'(MAX_HEADS) + HA'(hd_idx) : HA'(hd_idx);
    assign pp_gap  = (r_rz > r_bz) ? r_rz - r_bz : r_bz - r_rz;

    // Head, gap and protein stores
    always_ff @(posedge i_clk) begin
        if (hd_we) begin
            head_mem[hd_addr] <= {r_px, r_py, r_pz, r_kind};
        end
        if (hd_rd) begin
            r_hd_q <= head_mem[hd_addr];
        end
        if (gap_we) begin
            gap_mem[hd_addr] <= gap_wdata;
        end
        if (hd_rd) begin
            r_gap_q <= gap_mem[hd_addr];
        end
        if (pr_we) begin
            prot_mem[PIW'(r_pcnt)] <= {r_px, r_py};
        end
        if (pr_rd) begin
            r_pr_q <= prot_mem[r_j];
        end
    end

    // Distance unit operands
    assign dist_start = (r_state == S_PP_RDW) | (r_state == S_Q_RDW) |
                        (r_state == S_P_RDW);
    assign dist_ax = (r_state == S_PP_RDW) ? SEP_W'(r_rx) : r_cx;
    assign dist_ay = (r_state == S_PP_RDW) ? SEP_W'(r_ry) : r_cy;
    assign dist_bx = (r_state == S_P_RDW) ? SEP_W'({pm_x, 1'b0}) : SEP_W'({hd_x, 1'b0});
    assign dist_by = (r_state == S_P_RDW) ? SEP_W'({pm_y, 1'b0}) : SEP_W'({hd_y, 1'b0});

    mtg_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dist_start),
        .i_ax    (dist_ax),
        .i_ay    (dist_ay),
        .i_bx    (dist_bx),
        .i_by    (dist_by),
        .i_len_x ({r_box_x, 1'b0}),
        .i_len_y ({r_box_y, 1'b0}),
        .o_done  (dist_done),
        .o_d2    (dist_d2)
    );

    // Map access for the queried cell
    assign add_ok    = r_found & ~r_hit;
    assign map_sum   = {1'b0, map_rdata} + (SUM_W+1)'(r_bgap);
    assign map_wdata = map_sum[SUM_W] ? {SUM_W{1'b1}} : map_sum[SUM_W-1:0];
    assign fsum_sum  = {1'b0, r_fsum} + (SUM_W+1)'(r_bgap);

    always_comb begin
        map_ctl.rd  = (r_state == S_Q_MAPRD);
        map_ctl.wr  = (r_state == S_Q_MAPW) & add_ok;
        map_ctl.clr = (r_state == S_DECODE) & (r_op == OP_CLR_MAP);
    end

    mtg_map #(
        .MAX_GRID (MAX_GRID)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (map_ctl),
        .i_addr  (r_cell),
        .i_wdata (map_wdata),
        .o_rdata (map_rdata),
        .o_busy  (map_busy)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_x   <= RST_BOX;
            r_box_y   <= RST_BOX;
            r_step_x  <= RST_STEP;
            r_step_y  <= RST_STEP;
            r_grid    <= RST_GRID;
            r_prot_en <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BOX_X:   r_box_x   <= i_cfg_data;
                CFG_BOX_Y:   r_box_y   <= i_cfg_data;
                CFG_STEP_X:  r_step_x  <= i_cfg_data;
                CFG_STEP_Y:  r_step_y  <= i_cfg_data;
                CFG_GRID:    r_grid    <= i_cfg_data[GRID_W-1:0];
                CFG_PROT_EN: r_prot_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt0  <= '0;
            r_cnt1  <= '0;
            r_pcnt  <= '0;
            r_fsum  <= '0;
            r_fcnt  <= '0;
            r_k     <= '0;
            r_m     <= '0;
            r_j     <= '0;
            r_bk    <= '0;
            r_found <= 1'b0;
            r_op    <= '0;
            r_lf    <= 1'b0;
            r_px    <= '0;
            r_py    <= '0;
            r_pz    <= '0;
            r_kind  <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_thr   <= '0;
            r_best  <= '0;
            r_cx    <= '0;
            r_cy    <= '0;
            r_rx    <= '0;
            r_ry    <= '0;
            r_rz    <= '0;
            r_bz    <= '0;
            r_bkind <= '0;
            r_bgap  <= '0;
            r_cell  <= '0;
            r_st    <= ST_OK;
            r_nh    <= '0;
            r_nk    <= '0;
            r_gp    <= '0;
            r_hit   <= 1'b0;
            r_mt    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_op    <= i_in.op;
                        r_lf    <= i_in.leaflet;
                        r_px    <= in_px;
                        r_py    <= in_py;
                        r_pz    <= in_pz;
                        r_kind  <= i_in.lipid_kind;
                        r_col   <= i_in.cell_col;
                        r_row   <= i_in.cell_row;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_st    <= ST_OK;
                    r_nh    <= '0;
                    r_nk    <= '0;
                    r_gp    <= '0;
                    r_hit   <= 1'b0;
                    r_mt    <= '0;
                    r_thr   <= {(THR_W-2)'(r_box_x) * (THR_W-2)'(r_box_y), 2'b00};
                    r_cx    <= SEP_W'({r_col, 1'b1} * r_step_x);
                    r_cy    <= SEP_W'({r_row, 1'b1} * r_step_y);
                    r_cell  <= MA'(MA'(r_col) * MA'(MAX_GRID) + MA'(r_row));
                    r_k     <= '0;
                    r_state <= S_FIN;
                    case (r_op)
                        OP_CLR_FRAME: begin
                            r_cnt0 <= '0;
                            r_cnt1 <= '0;
                            r_pcnt <= '0;
                            r_fsum <= '0;
                            r_fcnt <= '0;
                        end
                        OP_LOAD_HEAD: begin
                            if (cnt_ref >= CW'(MAX_HEADS)) begin
                                r_st <= ST_FULL;
                            end else begin
                                r_nh <= NH_W'(cnt_ref);
                                if (r_lf) begin
                                    r_cnt1 <= r_cnt1 + CW'(1);
                                end else begin
                                    r_cnt0 <= r_cnt0 + CW'(1);
                                end
                            end
                        end
                        OP_LOAD_PROT: begin
                            if (r_pcnt >= PCW'(MAX_PROT)) begin
                                r_st <= ST_FULL;
                            end else begin
                                r_pcnt <= r_pcnt + PCW'(1);
                            end
                        end
                        OP_PAIR: begin
                            if (cnt_ref != '0) begin
                                r_state <= S_PP_REF;
                            end
                        end
                        OP_QUERY: begin
                            if ({1'b0, r_col} >= r_grid || {1'b0, r_row} >= r_grid ||
                                32'(r_col) >= MAX_GRID || 32'(r_row) >= MAX_GRID) begin
                                r_st <= ST_OUTSIDE;
                            end else begin
                                r_state <= S_Q_SETUP;
                            end
                        end
                        OP_CLR_MAP: r_state <= S_CLRW;
                        default: ;
                    endcase
                end
                S_CLRW: begin
                    if (!map_busy) begin
                        r_state <= S_FIN;
                    end
                end

                // Pair pass: one reference head against the other leaflet
                S_PP_REF: r_state <= S_PP_REFW;
                S_PP_REFW: begin
                    r_rx   <= {hd_x, 1'b0};
                    r_ry   <= {hd_y, 1'b0};
                    r_rz   <= hd_z;
                    r_bz   <= '0;
                    r_best <= D2_W'(r_thr);
                    r_m    <= '0;
                    r_state <= (cnt_oth == '0) ? S_PP_WR : S_PP_RD;
                end
                S_PP_RD:  r_state <= S_PP_RDW;
                S_PP_RDW: r_state <= S_PP_DIST;
                S_PP_DIST: begin
                    if (dist_done) begin
                        if (dist_d2 < r_best) begin
                            r_best <= dist_d2;
                            r_bz   <= hd_z;
                        end
                        r_m <= r_m + HIW'(1);
                        r_state <= (CW'(r_m) + CW'(1) == cnt_oth) ? S_PP_WR : S_PP_RD;
                    end
                end
                S_PP_WR: begin
                    r_k <= r_k + HIW'(1);
                    r_state <= (CW'(r_k) + CW'(1) == cnt_ref) ? S_FIN : S_PP_REF;
                end

                // Query: nearest head of the leaflet
                S_Q_SETUP: begin
                    r_best  <= D2_W'(r_thr);
                    r_found <= 1'b0;
                    r_bk    <= '0;
                    r_bkind <= '0;
                    r_bgap  <= '0;
                    r_state <= (cnt_ref == '0) ? S_Q_PROT0 : S_Q_RD;
                end
                S_Q_RD:  r_state <= S_Q_RDW;
                S_Q_RDW: r_state <= S_Q_DIST;
                S_Q_DIST: begin
                    if (dist_done) begin
                        if (dist_d2 < r_best) begin
                            r_best  <= dist_d2;
                            r_bk    <= r_k;
                            r_bkind <= hd_kind;
                            r_bgap  <= r_gap_q;
                            r_found <= 1'b1;
                        end
                        r_k <= r_k + HIW'(1);
                        r_state <= (CW'(r_k) + CW'(1) == cnt_ref) ? S_Q_PROT0 : S_Q_RD;
                    end
                end

                // Protein exclusion: stop at the first closer atom
                S_Q_PROT0: begin
                    r_j <= '0;
                    r_state <= (!r_prot_en || r_pcnt == '0) ? S_Q_MAPRD : S_P_RD;
                end
                S_P_RD:  r_state <= S_P_RDW;
                S_P_RDW: r_state <= S_P_DIST;
                S_P_DIST: begin
                    if (dist_done) begin
                        r_j <= r_j + PIW'(1);
                        if (dist_d2 < r_best) begin
                            r_hit   <= 1'b1;
                            r_state <= S_Q_MAPRD;
                        end else if (PCW'(r_j) + PCW'(1) == r_pcnt) begin
                            r_state <= S_Q_MAPRD;
                        end else begin
                            r_state <= S_P_RD;
                        end
                    end
                end
                S_Q_MAPRD: r_state <= S_Q_MAPW;
                S_Q_MAPW: begin
                    if (r_found) begin
                        r_nh <= NH_W'(r_bk);
                        r_nk <= r_bkind;
                        r_gp <= r_bgap;
                    end else begin
                        r_st <= ST_NONE;
                    end
                    if (add_ok) begin
                        r_mt   <= map_wdata;
                        r_fsum <= fsum_sum[SUM_W] ? {SUM_W{1'b1}} : fsum_sum[SUM_W-1:0];
                        if (r_fcnt != {HITS_W{1'b1}}) begin
                            r_fcnt <= r_fcnt + HITS_W'(1);
                        end
                    end else begin
                        r_mt <= map_rdata;
                    end
                    r_state <= S_FIN;
                end

                // Hand the result to the output register
                S_FIN: begin
                    if (!r_ov || o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_o_st  <= ST_OK;
            r_o_nh  <= '0;
            r_o_nk  <= '0;
            r_o_gp  <= '0;
            r_o_hit <= 1'b0;
            r_o_mt  <= '0;
            r_o_ft  <= '0;
            r_o_fh  <= '0;
        end else if (r_state == S_FIN && (!r_ov || o_out.ready)) begin
            r_ov    <= 1'b1;
            r_o_st  <= r_st;
            r_o_nh  <= r_nh;
            r_o_nk  <= r_nk;
            r_o_gp  <= r_gp;
            r_o_hit <= r_hit;
            r_o_mt  <= r_mt;
            r_o_ft  <= r_fsum;
            r_o_fh  <= r_fcnt;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.status       = r_o_st;
    assign o_out.nearest_head = r_o_nh;
    assign o_out.nearest_kind = r_o_nk;
    assign o_out.gap_value    = r_o_gp;
    assign o_out.protein_hit  = r_o_hit;
    assign o_out.map_total    = r_o_mt;
    assign o_out.frame_total  = r_o_ft;
    assign o_out.frame_hits   = r_o_fh;

endmodule
